// ===== hdl/lmcl_pkg.sv =====
`timescale 1ns / 1ps
package lmcl_pkg;
    localparam int PIXELS_DEF = 512;
    localparam logic [15:0] FULL_UA_RST = 16'd20000;
    localparam logic [15:0] MAX_MA_RST  = 16'd2000;
    localparam logic [24:0] TOTAL_MAX   = 25'h1FFFFFF;

    typedef enum logic [1:0] {
        CMD_WRITE  = 2'd0,
        CMD_FILL   = 2'd1,
        CMD_RENDER = 2'd2,
        CMD_READ   = 2'd3
    } t_cmd;

    localparam logic CFG_FULL = 1'b0;
    localparam logic CFG_MAX  = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture the item fields
        logic clr_sum;   // clear accumulator
        logic acc;       // add read data to accumulator
        logic calc;      // start current computation
        logic div_start; // start divider on current pixel
        logic wr_item;   // write pixel from item
        logic wr_fill;   // write fill color at sweep address
        logic wr_scale;  // write scaled pixel at sweep address
        logic rd_item;   // issue ram read at item index
        logic adr_clr;   // reset sweep address
        logic adr_inc;   // advance sweep address
        logic emit;      // drive a result
        logic emit_rd;   // result carries read data
        logic emit_rn;   // result carries render data
        logic emit_er;   // result carries error
    } t_ctl;

    // datapath to controller
    typedef struct packed {
        logic adr_last;
        logic calc_done;
        logic div_done;
        logic over;
        logic bad_xy;
    } t_sts;
endpackage

// ===== hdl/led_matrix_current_limiter.sv =====
`timescale 1ns / 1ps
// Frame store and current limiter for a 32x16 RGB matrix chained as two
// serpentine panels. Issue a command with start while busy is low; exactly
// one result per command appears on the o_ ports for one cycle with o_valid,
// and cannot be held off. After reset busy stays high while the frame memory
// is cleared. A fill makes one memory write per pixel. A render sums the frame
// through the single read port, and when the frame is over the limit scales
// each pixel with the bit-serial divider.
module led_matrix_current_limiter #(
    parameter int PIXELS = lmcl_pkg::PIXELS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_cmd,
    input  logic [5:0]  i_col_x,
    input  logic [4:0]  i_row_y,
    input  logic [7:0]  i_in_red,
    input  logic [7:0]  i_in_green,
    input  logic [7:0]  i_in_blue,
    input  logic [8:0]  i_chain_index,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_data,
    output logic        o_valid,
    output logic [7:0]  o_out_red,
    output logic [7:0]  o_out_green,
    output logic [7:0]  o_out_blue,
    output logic [24:0] o_total_current_ua,
    output logic        o_limited,
    output logic        o_error
);
    import lmcl_pkg::*;
    t_ctl ctl;
    t_sts sts;

    lmcl_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .i_cmd  (t_cmd'(i_cmd)),
        .i_sts  (sts),
        .busy   (busy),
        .o_ctl  (ctl)
    );

    lmcl_dp #(.PIXELS(PIXELS)) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ctl             (ctl),
        .i_col_x           (i_col_x),
        .i_row_y           (i_row_y),
        .i_in_red          (i_in_red),
        .i_in_green        (i_in_green),
        .i_in_blue         (i_in_blue),
        .i_chain_index     (i_chain_index),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_addr[0]),
        .i_cfg_hi          (1'b0),
        .i_cfg_data        (i_cfg_data),
        .o_sts             (sts),
        .o_strobe          (o_valid),
        .o_out_red         (o_out_red),
        .o_out_green       (o_out_green),
        .o_out_blue        (o_out_blue),
        .o_total_current_ua(o_total_current_ua),
        .o_limited         (o_limited),
        .o_error           (o_error)
    );
endmodule

// ===== hdl/lmcl_ram.sv =====
`timescale 1ns / 1ps
module lmcl_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

// ===== hdl/lmcl_ctrl.sv =====
`timescale 1ns / 1ps
module lmcl_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  lmcl_pkg::t_cmd i_cmd,
    input  lmcl_pkg::t_sts i_sts,
    output logic           busy,
    output lmcl_pkg::t_ctl o_ctl
);
    import lmcl_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CLEAR, S_DECODE, S_FILL, S_RD_WAIT, S_SUM_RD, S_SUM_LAST,
        S_CALC, S_SC_RD, S_SC_DIV, S_SC_WR, S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_inited, n_inited;
    t_cmd   r_cmd, n_cmd;
    logic   r_limited, n_limited;
    t_ctl   n_ctl;

    always_comb begin
        n_state   = r_state;
        n_inited  = r_inited;
        n_cmd     = r_cmd;
        n_limited = r_limited;
        n_ctl     = '0;
        case (r_state)
            S_CLEAR: begin
                n_ctl.wr_fill = 1'b1;
                n_ctl.adr_inc = 1'b1;
                if (i_sts.adr_last) begin
                    n_inited = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_ctl.load = 1'b1;
                    n_cmd      = i_cmd;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                n_ctl.adr_clr = 1'b1;
                case (r_cmd)
                    CMD_WRITE: begin
                        n_ctl.wr_item = ~i_sts.bad_xy;
                        n_ctl.emit    = 1'b1;
                        n_ctl.emit_er = i_sts.bad_xy;
                        n_state       = S_IDLE;
                    end
                    CMD_FILL:   n_state = S_FILL;
                    CMD_RENDER: begin
                        n_ctl.clr_sum = 1'b1;
                        n_state       = S_SUM_RD;
                    end
                    default: begin
                        n_ctl.rd_item = 1'b1;
                        n_state       = S_RD_WAIT;
                    end
                endcase
            end
            S_RD_WAIT: begin
                n_ctl.emit    = 1'b1;
                n_ctl.emit_rd = 1'b1;
                n_state       = S_IDLE;
            end
            S_FILL: begin
                n_ctl.wr_fill = 1'b1;
                n_ctl.adr_inc = 1'b1;
                if (i_sts.adr_last) begin
                    n_ctl.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            // read every pixel; the sum takes each pixel's data in the cycle after its address
            S_SUM_RD: begin
                n_ctl.acc     = (r_limited);
                n_ctl.adr_inc = 1'b1;
                n_limited     = 1'b1;
                if (i_sts.adr_last) n_state = S_SUM_LAST;
            end
            S_SUM_LAST: begin
                n_ctl.acc = 1'b1;
                n_limited = 1'b0;
                n_ctl.calc = 1'b1;
                n_state   = S_CALC;
            end
            S_CALC: begin
                n_ctl.adr_clr = 1'b1;
                if (i_sts.calc_done) begin
                    n_limited = i_sts.over;
                    if (i_sts.over) n_state = S_SC_RD;
                    else            n_state = S_DONE;
                end
            end
            S_SC_RD: begin
                n_state  = S_SC_DIV;
            end
            S_SC_DIV: begin
                n_ctl.div_start = 1'b1;
                n_state         = S_SC_WR;
            end
            S_SC_WR: begin
                if (i_sts.div_done) begin
                    n_ctl.wr_scale = 1'b1;
                    n_ctl.adr_inc  = 1'b1;
                    n_state        = i_sts.adr_last ? S_DONE : S_SC_RD;
                end
            end
            S_DONE: begin
                n_ctl.emit    = 1'b1;
                n_ctl.emit_rn = 1'b1;
                n_limited     = 1'b0;
                n_state       = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_inited  <= 1'b0;
            r_cmd     <= CMD_WRITE;
            r_limited <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_inited  <= n_inited;
            r_cmd     <= n_cmd;
            r_limited <= n_limited;
        end
    end

    assign busy  = (r_state != S_IDLE) || !r_inited;
    assign o_ctl = n_ctl;
endmodule

// ===== hdl/lmcl_dp.sv =====
`timescale 1ns / 1ps
module lmcl_dp #(
    parameter int PIXELS = lmcl_pkg::PIXELS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  lmcl_pkg::t_ctl i_ctl,
    input  logic [5:0]     i_col_x,
    input  logic [4:0]     i_row_y,
    input  logic [7:0]     i_in_red,
    input  logic [7:0]     i_in_green,
    input  logic [7:0]     i_in_blue,
    input  logic [8:0]     i_chain_index,
    input  logic           i_cfg_we,
    input  logic           i_cfg_idx,
    input  logic           i_cfg_hi,
    input  logic [15:0]    i_cfg_data,
    output lmcl_pkg::t_sts o_sts,
    output logic           o_strobe,
    output logic [7:0]     o_out_red,
    output logic [7:0]     o_out_green,
    output logic [7:0]     o_out_blue,
    output logic [24:0]    o_total_current_ua,
    output logic           o_limited,
    output logic           o_error
);
    import lmcl_pkg::*;
    localparam int AW = $clog2(PIXELS);

    logic [15:0] r_full_ua, r_max_ma;
    logic [5:0]  r_x;
    logic [4:0]  r_y;
    logic [23:0] r_rgb;
    logic [AW-1:0] r_idx, r_adr;
    logic [18:0] r_sum;
    logic [23:0] rdata;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full_ua <= FULL_UA_RST;
            r_max_ma  <= MAX_MA_RST;
        end else if (i_cfg_we && !i_cfg_hi) begin
            if (i_cfg_idx == CFG_FULL) r_full_ua <= i_cfg_data;
            else                       r_max_ma  <= i_cfg_data;
        end
    end

    // item capture; sweep address
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_x   <= i_col_x;
            r_y   <= i_row_y;
            r_rgb <= {i_in_red, i_in_green, i_in_blue};
            r_idx <= i_chain_index[AW-1:0];
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)           r_adr <= '0;
        else if (i_ctl.adr_clr) r_adr <= '0;
        else if (i_ctl.adr_inc) r_adr <= r_adr + 1'b1;
    end

    // chain mapping
    logic [4:0] ix;
    logic [2:0] rr, slot;
    logic [8:0] pos;
    assign ix     = 5'd31 - r_x[4:0];
    assign rr     = r_y[2:0];
    assign slot   = ix[0] ? rr : (3'd7 - rr);
    assign pos    = {~r_y[3], ix, slot};
    assign o_sts.bad_xy = (r_x > 6'd31) || (r_y > 5'd15);

    // sum of channels, pixel data arrives in the cycle after the read
    always_ff @(posedge i_clk) begin
        if (i_ctl.clr_sum)  r_sum <= '0;
        else if (i_ctl.acc) r_sum <= r_sum + 19'(rdata[23:16]) + 19'(rdata[15:8])
                                           + 19'(rdata[7:0]);
    end

    // current: product, then divide by 255 via multiply-by-reciprocal
    logic [1:0]  r_cst;
    logic [34:0] r_prod;
    logic [26:0] r_cur;
    logic [25:0] r_lim;
    logic [42:0] r_q;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cst <= '0;
        else if (i_ctl.calc) r_cst <= 2'd1;
        else if (r_cst != 2'd0) r_cst <= (r_cst == 2'd3) ? 2'd0 : r_cst + 2'd1;
    end
    always_ff @(posedge i_clk) begin
        r_prod <= 35'(r_sum) * 35'(r_full_ua);
        r_lim  <= 26'(r_max_ma) * 26'd1000;
        // q approximates p/255 as (p + p>>8 + p>>16 + p>>24) >> 8, made exact via correction
        r_q    <= 43'(r_prod) + 43'(r_prod >> 8) + 43'(r_prod >> 16) + 43'(r_prod >> 24);
    end
    // correction: estimate is at most three below the true quotient
    logic [34:0] est;
    logic [34:0] rem;
    assign est = 35'(r_q >> 8);
    assign rem = r_prod - 35'(est * 35'd255);
    logic [26:0] n_cur;
    always_comb begin
        logic [34:0] c;
        c = est;
        if (rem >= 35'd255)  c = c + 35'd1;
        if (rem >= 35'd510)  c = c + 35'd1;
        if (rem >= 35'd765)  c = c + 35'd1;
        n_cur = 27'(c);
    end
    always_ff @(posedge i_clk) begin
        if (r_cst == 2'd3) r_cur <= n_cur;
    end
    assign o_sts.calc_done = (r_cst == 2'd0) && !i_ctl.calc;
    assign o_sts.over      = r_cur > {1'b0, r_lim};

    // shared restoring divider: three channels of c*lim / cur in parallel
    logic [5:0]  r_dcnt;
    logic        r_dbusy;
    logic [33:0] r_num [3];
    logic [26:0] r_rem [3];
    logic [7:0]  r_quo [3];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dbusy <= 1'b0;
            r_dcnt  <= '0;
        end else if (i_ctl.div_start) begin
            r_dbusy <= 1'b1;
            r_dcnt  <= 6'd34;
        end else if (r_dbusy) begin
            r_dcnt <= r_dcnt - 6'd1;
            if (r_dcnt == 6'd1) r_dbusy <= 1'b0;
        end
    end
    for (genvar k = 0; k < 3; k++) begin : g_div
        logic [27:0] trial;
        logic [27:0] diff;
        assign trial = {r_rem[k], r_num[k][33]};
        assign diff  = trial - {1'b0, r_cur};
        always_ff @(posedge i_clk) begin
            if (i_ctl.div_start) begin
                r_num[k] <= 34'(rdata[8*k +: 8]) * 34'(r_lim);
                r_rem[k] <= '0;
                r_quo[k] <= '0;
            end else if (r_dbusy) begin
                r_num[k] <= r_num[k] << 1;
                if (trial >= {1'b0, r_cur}) begin
                    r_rem[k] <= diff[26:0];
                    r_quo[k] <= {r_quo[k][6:0], 1'b1};
                end else begin
                    r_rem[k] <= trial[26:0];
                    r_quo[k] <= {r_quo[k][6:0], 1'b0};
                end
            end
        end
    end
    assign o_sts.div_done = !r_dbusy && !i_ctl.div_start;
    assign o_sts.adr_last = (r_adr == AW'(PIXELS - 1));

    // frame store
    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [23:0]   wdata;
    always_comb begin
        we    = i_ctl.wr_item | i_ctl.wr_fill | i_ctl.wr_scale;
        waddr = i_ctl.wr_item ? pos[AW-1:0] : r_adr;
        if (i_ctl.wr_scale)    wdata = {r_quo[2], r_quo[1], r_quo[0]};
        else if (i_ctl.wr_fill) wdata = i_ctl.load ? 24'd0 : r_rgb;
        else                   wdata = r_rgb;
        raddr = i_ctl.rd_item ? r_idx : r_adr;
    end
    logic r_init;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_init <= 1'b0;
        else if (i_ctl.load) r_init <= 1'b1;
    end
    lmcl_ram #(.WIDTH(24), .DEPTH(PIXELS)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(r_init ? wdata : 24'd0),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    // result outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_strobe <= 1'b0;
        else          o_strobe <= i_ctl.emit;
        o_out_red          <= i_ctl.emit_rd ? rdata[23:16] : 8'd0;
        o_out_green        <= i_ctl.emit_rd ? rdata[15:8]  : 8'd0;
        o_out_blue         <= i_ctl.emit_rd ? rdata[7:0]   : 8'd0;
        o_total_current_ua <= !i_ctl.emit_rn ? 25'd0 :
                              (r_cur > 27'(TOTAL_MAX)) ? TOTAL_MAX : r_cur[24:0];
        o_limited          <= i_ctl.emit_rn && (r_cur > {1'b0, r_lim});
        o_error            <= i_ctl.emit_er;
    end
endmodule

// ===== hdl/lmcl_checker.sv =====
`timescale 1ns / 1ps
module lmcl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic        o_limited,
    input logic        o_error,
    input logic [24:0] o_total_current_ua
);
    // a command always raises busy on the next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("busy not raised");
    // results only while a command is in flight
    a_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy)) else $error("result without command");
    // error and limiting never together
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_error && o_limited)) else $error("error with limited");
    // limited implies nonzero current
    a_lim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_limited) |-> (o_total_current_ua != 25'd0))
        else $error("limited with zero current");
endmodule

bind led_matrix_current_limiter lmcl_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_valid(o_valid), .o_limited(o_limited), .o_error(o_error),
    .o_total_current_ua(o_total_current_ua)
);

// ===== tb/sv/led_matrix_current_limiter_test.sv =====
`timescale 1ns / 1ps
module led_matrix_current_limiter_test;
    import lmcl_pkg::*;

    typedef struct {
        t_cmd        cmd;
        logic [5:0]  col_x;
        logic [4:0]  row_y;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [8:0]  chain_index;
    } t_item;

    typedef struct {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [24:0] total_ua;
        logic        limited;
        logic        error;
    } t_result;

    // frame model and queue of pending results
    class frame_scoreboard;
        logic [23:0] frame [512];
        logic [18:0] level_sum;
        logic [15:0] full_ua;
        logic [15:0] max_ma;
        t_result     pending [$];
        int          mismatches;
        int          n_render, n_limited, n_error, n_read;

        function void clear();
            foreach (frame[i]) frame[i] = '0;
            level_sum = '0;
            full_ua = FULL_UA_RST;
            max_ma = MAX_MA_RST;
        endfunction

        function int panel_pos(logic [5:0] x, logic [4:0] y);
            int ix;
            int r;
            ix = 31 - int'(x);
            r = int'(y[2:0]);
            return ((y < 8) ? 256 : 0) + ix * 8 + (ix[0] ? r : 7 - r);
        endfunction

        function void set_reg(logic idx, logic [15:0] val);
            if (idx == CFG_FULL) full_ua = val;
            else max_ma = val;
        endfunction

        // compute the result of one accepted item
        function void note_item(t_item it);
            t_result res;
            logic [63:0] cur;
            logic [63:0] lim;
            logic [31:0] acc;
            logic [23:0] p;
            res = '{default: '0};
            case (it.cmd)
                CMD_WRITE: begin
                    if (it.col_x > 31 || it.row_y > 15) begin
                        res.error = 1'b1;
                        n_error++;
                    end else begin
                        frame[panel_pos(it.col_x, it.row_y)] = {it.red, it.green, it.blue};
                    end
                end
                CMD_FILL: begin
                    foreach (frame[i]) frame[i] = {it.red, it.green, it.blue};
                end
                CMD_RENDER: begin
                    acc = 0;
                    foreach (frame[i]) acc += frame[i][23:16] + frame[i][15:8] + frame[i][7:0];
                    level_sum = acc[18:0];
                    cur = (64'(level_sum) * 64'(full_ua)) / 64'd255;
                    lim = 64'(max_ma) * 64'd1000;
                    res.total_ua = (cur > 64'(TOTAL_MAX)) ? TOTAL_MAX : cur[24:0];
                    n_render++;
                    if (cur > lim) begin
                        res.limited = 1'b1;
                        n_limited++;
                        foreach (frame[i]) begin
                            p = frame[i];
                            frame[i] = {8'((64'(p[23:16]) * lim) / cur),
                                        8'((64'(p[15:8]) * lim) / cur),
                                        8'((64'(p[7:0]) * lim) / cur)};
                        end
                    end
                end
                default: begin
                    p = frame[it.chain_index];
                    {res.red, res.green, res.blue} = p;
                    n_read++;
                end
            endcase
            pending.push_back(res);
        endfunction

        function void report(string what);
            $display("mismatch at %0t: %s", $time, what);
            mismatches++;
        endfunction

        // compare one result with the oldest expectation
        function void check_result(t_result got);
            t_result exp;
            if (pending.size() == 0) begin
                report("result with nothing expected");
                return;
            end
            exp = pending.pop_front();
            if (got.red !== exp.red)
                report($sformatf("red %0d, expected %0d", got.red, exp.red));
            if (got.green !== exp.green)
                report($sformatf("green %0d, expected %0d", got.green, exp.green));
            if (got.blue !== exp.blue)
                report($sformatf("blue %0d, expected %0d", got.blue, exp.blue));
            if (got.total_ua !== exp.total_ua)
                report($sformatf("current %0d, expected %0d", got.total_ua, exp.total_ua));
            if (got.limited !== exp.limited)
                report($sformatf("limited %b, expected %b", got.limited, exp.limited));
            if (got.error !== exp.error)
                report($sformatf("error %b, expected %b", got.error, exp.error));
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_cmd;
    logic [5:0]  i_col_x;
    logic [4:0]  i_row_y;
    logic [7:0]  i_in_red, i_in_green, i_in_blue;
    logic [8:0]  i_chain_index;
    logic        i_cfg_we;
    logic [0:0]  i_cfg_addr;
    logic [15:0] i_cfg_data;
    logic        o_valid;
    logic [7:0]  o_out_red, o_out_green, o_out_blue;
    logic [24:0] o_total_current_ua;
    logic        o_limited, o_error;

    frame_scoreboard sb;
    bit              no_idle;
    int              renders_left;

    led_matrix_current_limiter DUT (.*);

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // check every result in the cycle it is shown
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            sb.check_result('{o_out_red, o_out_green, o_out_blue,
                              o_total_current_ua, o_limited, o_error});
    end

    task automatic send_item(t_item it);
        int gap;
        gap = 0;
        if (!no_idle && $urandom_range(99) < 26) gap = $urandom_range(4, 1);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= it.cmd;
        i_col_x <= it.col_x;
        i_row_y <= it.row_y;
        i_in_red <= it.red;
        i_in_green <= it.green;
        i_in_blue <= it.blue;
        i_chain_index <= it.chain_index;
        do @(posedge i_clk); while (busy);
        sb.note_item(it);
    endtask

    // hold off until every result is in and the block is idle
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0 || busy) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        sb.set_reg(idx, val);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_item mk(t_cmd c, int x, int y, int r, int g, int b, int idx);
        t_item it;
        it = '{c, 6'(x), 5'(y), 8'(r), 8'(g), 8'(b), 9'(idx)};
        return it;
    endfunction

    // mostly pixel traffic; whole-frame commands are rare since they are slow
    function automatic t_item random_item();
        t_item it;
        int    pick;
        it = mk(CMD_READ, $urandom_range(63), $urandom_range(31), $urandom_range(255),
                $urandom_range(255), $urandom_range(255), $urandom_range(511));
        if ($urandom_range(99) < 85) begin
            it.col_x = 6'($urandom_range(31));
            it.row_y = 5'($urandom_range(15));
        end
        pick = $urandom_range(99);
        if (pick < 48) it.cmd = CMD_WRITE;
        else if (pick < 52) it.cmd = CMD_FILL;
        else if (pick < 57 && renders_left > 0) begin
            it.cmd = CMD_RENDER;
            renders_left--;
        end
        return it;
    endfunction

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++) begin
            // let results catch up once mid-phase
            if (i == count / 2) drain();
            send_item(random_item());
        end
    endtask

    initial begin
        sb = new();
        sb.clear();
        no_idle = 1'b0;
        renders_left = 28;
        start = 1'b0;
        i_cmd = CMD_WRITE;
        i_col_x = '0;
        i_row_y = '0;
        i_in_red = '0;
        i_in_green = '0;
        i_in_blue = '0;
        i_chain_index = '0;
        i_cfg_we = 1'b0;
        i_cfg_addr = CFG_FULL;
        i_cfg_data = '0;
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);

        // corners, out-of-range writes, reads at both chain ends, limiting
        send_item(mk(CMD_READ, 0, 0, 0, 0, 0, 0));
        send_item(mk(CMD_WRITE, 0, 0, 255, 0, 0, 0));
        send_item(mk(CMD_WRITE, 31, 15, 0, 255, 0, 0));
        send_item(mk(CMD_WRITE, 31, 0, 0, 0, 255, 0));
        send_item(mk(CMD_WRITE, 0, 15, 255, 255, 255, 0));
        send_item(mk(CMD_WRITE, 30, 8, 1, 2, 3, 0));
        send_item(mk(CMD_WRITE, 32, 0, 9, 9, 9, 0));
        send_item(mk(CMD_WRITE, 63, 31, 9, 9, 9, 0));
        send_item(mk(CMD_WRITE, 5, 16, 9, 9, 9, 0));
        send_item(mk(CMD_READ, 0, 0, 0, 0, 0, 511));
        send_item(mk(CMD_READ, 0, 0, 0, 0, 0, 256));
        send_item(mk(CMD_READ, 0, 0, 0, 0, 0, 7));
        send_item(mk(CMD_READ, 0, 0, 0, 0, 0, 255));
        send_item(mk(CMD_RENDER, 0, 0, 0, 0, 0, 0));
        send_item(mk(CMD_FILL, 0, 0, 200, 100, 50, 0));
        send_item(mk(CMD_RENDER, 0, 0, 0, 0, 0, 0));
        send_item(mk(CMD_READ, 0, 0, 0, 0, 0, 300));
        send_item(mk(CMD_RENDER, 0, 0, 0, 0, 0, 0));
        send_item(mk(CMD_FILL, 0, 0, 255, 255, 255, 0));
        drain();

        // full scale at its top: current saturates and the exact value still limits
        write_reg(CFG_FULL, 16'hFFFF);
        write_reg(CFG_MAX, 16'hFFFF);
        send_item(mk(CMD_RENDER, 0, 0, 0, 0, 0, 0));
        send_item(mk(CMD_READ, 0, 0, 0, 0, 0, 100));
        random_phase(140);
        drain();

        // zero limit scales any lit frame to black
        write_reg(CFG_MAX, 16'h0000);
        random_phase(150);
        drain();

        // zero full scale never limits; run without idling
        write_reg(CFG_FULL, 16'h0000);
        write_reg(CFG_MAX, 16'hFFFF);
        no_idle = 1'b1;
        random_phase(150);
        no_idle = 1'b0;
        drain();

        write_reg(CFG_FULL, 16'd20000);
        write_reg(CFG_MAX, 16'd2000);
        random_phase(140);
        drain();

        write_reg(CFG_FULL, 16'($urandom_range(65535)));
        write_reg(CFG_MAX, 16'($urandom_range(3000)));
        random_phase(150);
        drain();
        repeat (40) @(posedge i_clk);

        $display("covered %0d renders (%0d limited), %0d reads, %0d rejected writes",
                 sb.n_render, sb.n_limited, sb.n_read, sb.n_error);
        $display("register settings: reset values, both extremes and random values");
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // watchdog
    initial begin
        #50ms;
        $display("timeout");
        $display("status: fail");
        $finish;
    end
endmodule
